// File: hw/rtl/skit_pkg.sv
// ----------------------------------------------------------------------------
// skit_pkg
// Shared types and constants for the sorted key/index table.
// ----------------------------------------------------------------------------
`default_nettype none

package skit_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 31;
    localparam int USED_W  = 9;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [VALUE_W-1:0] value_t;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    // One stored table entry.
    typedef struct packed {
        key_t   key;
        value_t value;
    } entry_t;

    // Memory access request from the sequencer.
    typedef struct packed {
        logic   re;
        addr_t  raddr;
        logic   we;
        addr_t  waddr;
        entry_t wdata;
    } mem_req_t;

    // Finished result handed to the output stage.
    typedef struct packed {
        status_t status;
        value_t  found;
        cnt_t    count;
    } result_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LO_ISSUE,
        S_LO_CMP,
        S_HI_ISSUE,
        S_HI_CMP,
        S_DISPATCH,
        S_LOOK_WAIT,
        S_INS_SHIFT,
        S_REM_SHIFT,
        S_UPD,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/skit_ram.sv
// ----------------------------------------------------------------------------
// skit_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skit_ram
    import skit_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output entry_t        rdata
);

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/skit_ctrl.sv
// ----------------------------------------------------------------------------
// skit_ctrl
// Sequencer: two binary searches over the sorted memory, then the lookup,
// the shift for insert or remove, or the rewrite sweep for update.
// ----------------------------------------------------------------------------
`default_nettype none

module skit_ctrl
    import skit_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire op_t    in_op,
    input  wire key_t   in_key,
    input  wire value_t in_value,
    output mem_req_t    mem_req,
    input  wire entry_t rdata,
    output logic        res_valid,
    input  wire logic   res_ready,
    output result_t     res
);

    // Control state.
    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    logic    rd_live_reg, rd_live_next;

    // Request and working registers.
    op_t     op_reg, op_next;
    key_t    key_reg, key_next;
    value_t  val_reg, val_next;
    cnt_t    lo_reg, lo_next;
    cnt_t    hi_reg, hi_next;
    cnt_t    mid_reg, mid_next;
    cnt_t    first_reg, first_next;
    cnt_t    last_reg, last_next;
    cnt_t    ptr_reg, ptr_next;
    addr_t   wr_addr_reg, wr_addr_next;
    status_t status_reg, status_next;
    value_t  found_reg, found_next;

    logic    hit;
    logic    full;
    cnt_t    mid;
    cnt_t    ptr_dec;
    cnt_t    rem_dst;

    assign hit     = (first_reg < last_reg);
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign mid     = CNT_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign ptr_dec = ptr_reg - CNT_W'(1);
    assign rem_dst = ptr_reg - last_reg + first_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LO_ISSUE;
                end
            end
            S_LO_ISSUE:  state_next = (lo_reg < hi_reg) ? S_LO_CMP : S_HI_ISSUE;
            S_LO_CMP:    state_next = S_LO_ISSUE;
            S_HI_ISSUE:  state_next = (lo_reg < hi_reg) ? S_HI_CMP : S_DISPATCH;
            S_HI_CMP:    state_next = S_HI_ISSUE;
            S_DISPATCH:
            begin
                unique case (op_reg)
                    OP_LOOKUP: state_next = hit ? S_LOOK_WAIT : S_DONE;
                    OP_INSERT: state_next = full ? S_DONE : S_INS_SHIFT;
                    OP_REMOVE: state_next = hit ? S_REM_SHIFT : S_DONE;
                    OP_UPDATE: state_next = hit ? S_UPD : S_DONE;
                    default:   state_next = S_DONE;
                endcase
            end
            S_LOOK_WAIT: state_next = S_DONE;
            S_INS_SHIFT:
            begin
                if (!rd_live_reg && ptr_reg == last_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_REM_SHIFT:
            begin
                if (!rd_live_reg && ptr_reg >= count_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_UPD:
            begin
                if (ptr_reg >= last_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and memory requests.
    always_comb
    begin
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        mem_req      = '0;
        count_next   = count_reg;
        rd_live_next = rd_live_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        ptr_next     = ptr_reg;
        wr_addr_next = wr_addr_reg;
        status_next  = status_reg;
        found_next   = found_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next  = in_op;
                    key_next = in_key;
                    val_next = in_value;
                    lo_next  = '0;
                    hi_next  = count_reg;
                end
            end

            // Lower bound: first entry whose key is not less than the request key.
            S_LO_ISSUE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next      = mid;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = mid[ADDR_W-1:0];
                end
                else
                begin
                    first_next = lo_reg;
                    hi_next    = count_reg;
                end
            end
            S_LO_CMP:
            begin
                if ($signed(rdata.key) < $signed(key_reg))
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end

            // Upper bound: first entry whose key is greater, starting from the lower bound.
            S_HI_ISSUE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next      = mid;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = mid[ADDR_W-1:0];
                end
                else
                begin
                    last_next = lo_reg;
                end
            end
            S_HI_CMP:
            begin
                if ($signed(rdata.key) <= $signed(key_reg))
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end

            S_DISPATCH:
            begin
                status_next  = STAT_OK;
                found_next   = '0;
                rd_live_next = 1'b0;
                unique case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (hit)
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = first_reg[ADDR_W-1:0];
                        end
                        else
                        begin
                            status_next = STAT_MISSING;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ptr_next = count_reg;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit)
                        begin
                            ptr_next = last_reg;
                        end
                        else
                        begin
                            status_next = STAT_MISSING;
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (hit)
                        begin
                            ptr_next = first_reg;
                        end
                        else
                        begin
                            status_next = STAT_MISSING;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_MISSING;
                    end
                endcase
            end

            S_LOOK_WAIT:
            begin
                found_next = rdata.value;
            end

            // Move entries up by one from the top down, then write the new pair.
            S_INS_SHIFT:
            begin
                if (rd_live_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = wr_addr_reg;
                    mem_req.wdata = rdata;
                end
                if (ptr_reg > last_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_dec[ADDR_W-1:0];
                    wr_addr_next  = ptr_reg[ADDR_W-1:0];
                    ptr_next      = ptr_dec;
                    rd_live_next  = 1'b1;
                end
                else
                begin
                    rd_live_next = 1'b0;
                    if (!rd_live_reg)
                    begin
                        mem_req.we          = 1'b1;
                        mem_req.waddr       = last_reg[ADDR_W-1:0];
                        mem_req.wdata.key   = key_reg;
                        mem_req.wdata.value = val_reg;
                        count_next          = count_reg + CNT_W'(1);
                    end
                end
            end

            // Move the entries above the matching run down over it.
            S_REM_SHIFT:
            begin
                if (rd_live_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = wr_addr_reg;
                    mem_req.wdata = rdata;
                end
                if (ptr_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[ADDR_W-1:0];
                    wr_addr_next  = rem_dst[ADDR_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                    rd_live_next  = 1'b1;
                end
                else
                begin
                    rd_live_next = 1'b0;
                    if (!rd_live_reg)
                    begin
                        count_next = count_reg - (last_reg - first_reg);
                    end
                end
            end

            // Every entry of the matching run shares the key, so write it back whole.
            S_UPD:
            begin
                if (ptr_reg < last_reg)
                begin
                    mem_req.we          = 1'b1;
                    mem_req.waddr       = ptr_reg[ADDR_W-1:0];
                    mem_req.wdata.key   = key_reg;
                    mem_req.wdata.value = val_reg;
                    ptr_next            = ptr_reg + CNT_W'(1);
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
            end

            default:
            begin
                rd_live_next = 1'b0;
            end
        endcase
    end

    assign res.status = status_reg;
    assign res.found  = found_reg;
    assign res.count  = count_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_live_reg <= rd_live_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_key_index_table.sv
// ----------------------------------------------------------------------------
// sorted_key_index_table
// Table of (key, record index) pairs kept sorted by signed key in one memory.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   --------------------------------------
//   in        in_valid / in_ready    op, key, record_value
//   out       out_valid / out_ready  status, found_value, entries_used
//
// One request at a time. Each request runs two binary searches, each step a
// memory read, then a compare. Insert and remove then shift the entries above
// the match one per cycle through the single read and write port; update
// rewrites one matching entry per cycle. Reset clears the entry count; the
// memory holds no reset value. A result waits in the output register while
// the next request is already taken.
//
`default_nettype none

module sorted_key_index_table
    import skit_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] key,
    input  wire logic [30:0]        record_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [30:0]             found_value,
    output logic [8:0]              entries_used
);

    mem_req_t mem_req;
    entry_t   rdata;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic     out_valid_reg, out_valid_next;
    result_t  out_reg, out_next;

    // Sequencer.
    skit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (op_t'(op)),
        .in_key    (key_t'(key)),
        .in_value  (record_value),
        .mem_req   (mem_req),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Entry memory.
    skit_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // Output register: loads when empty or when its result is being taken.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign found_value  = out_reg.found;
    assign entries_used = USED_W'(out_reg.count);

`ifndef SYNTHESIS
    // A taken request occupies the sequencer, which then drops in_ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after a request was taken");

    // Only a successful lookup carries a record index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (found_value == '0))
        else $error("found_value nonzero on a failed request");

    // A full report only comes from a table at full depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_FULL) |-> (entries_used == USED_W'(TABLE_DEPTH)))
        else $error("table full reported below full depth");

    // The status code is never the unused one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_OK || status == STAT_MISSING || status == STAT_FULL))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire
